FILE: sv/lfu_pkg.sv
// ----------------------------------------------------------------------------
// LFU table package
// Sizes, codes and the entry layout of the LFU table; the table sizes its RAM from them.
// ----------------------------------------------------------------------------
package lfu_pkg;

  localparam int CAPACITY   = 16;
  localparam int COUNT_BITS = 16;

  localparam int KEY_W   = 32;
  localparam int VAL_W   = 32;
  localparam int STAMP_W = 32;
  localparam int CFG_W   = 5;

  localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int CMP_W = (CNT_W > CFG_W) ? CNT_W : CFG_W;

  localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(CAPACITY - 1);
  localparam logic [CFG_W-1:0] CAP_RESET = CFG_W'(16);

  localparam logic MODE_GET = 1'b0;
  localparam logic MODE_PUT = 1'b1;

  localparam logic [VAL_W-1:0] MISS_VALUE = '1;

  typedef struct packed {
    logic                  vld;
    logic [KEY_W-1:0]      key;
    logic [VAL_W-1:0]      value;
    logic [COUNT_BITS-1:0] count;
    logic [STAMP_W-1:0]    last;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

endpackage

FILE: sv/lfu_cache_table.sv
// ----------------------------------------------------------------------------
// LFU cache table
// Fully associative key/value table, LFU replacement, oldest-access tie-break.
// Each request scans the entry RAM one entry per cycle, then decides; busy
// stays high until it is done, so a new item waits for the last. A put that
// evicts above a lower free entry also passes an invalidate state. Reset
// runs a clearing pass over all entries, with busy high.
// ----------------------------------------------------------------------------
module lfu_cache_table (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  output logic                       busy,
  input  logic                       in_mode,
  input  logic [lfu_pkg::KEY_W-1:0]  in_lookup_key,
  input  logic [lfu_pkg::VAL_W-1:0]  in_store_value,
  output logic                       out_valid,
  output logic                       out_hit,
  output logic [lfu_pkg::VAL_W-1:0]  out_read_value,
  output logic                       out_evicted,
  output logic [lfu_pkg::KEY_W-1:0]  out_evicted_key,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [lfu_pkg::CFG_W-1:0]  cfg_capacity_in_use
);

  import lfu_pkg::*;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_DECIDE,
    ST_INVAL
  } state_t;

  state_t state_r;

  logic [CFG_W-1:0]   cap_r;
  logic [CNT_W-1:0]   occ_r;
  logic [STAMP_W-1:0] access_stamp_r;
  logic [IDX_W-1:0]   clr_idx_r;
  logic [IDX_W-1:0]   scan_idx_r;
  logic               issue_done_r;
  logic               rd_vld_r;
  logic [IDX_W-1:0]   rd_idx_r;

  logic               out_valid_r;
  logic               out_hit_r;
  logic [VAL_W-1:0]   out_read_value_r;
  logic               out_evicted_r;
  logic [KEY_W-1:0]   out_evicted_key_r;

  logic               mode_r;
  logic [KEY_W-1:0]   key_r;
  logic [VAL_W-1:0]   val_r;
  logic [STAMP_W-1:0] stamp_r;

  logic               match_found_r;
  logic [IDX_W-1:0]   match_idx_r;
  entry_t             match_ent_r;
  logic               vict_found_r;
  logic [IDX_W-1:0]   vict_idx_r;
  logic [KEY_W-1:0]   vict_key_r;
  logic [COUNT_BITS-1:0] vict_cnt_r;
  logic [STAMP_W-1:0] vict_last_r;
  logic               free_found_r;
  logic [IDX_W-1:0]   free_idx_r;

  logic               accept;
  logic               issue;
  logic               scan_last;
  logic [ENTRY_W-1:0] rd_word;
  entry_t             rd_ent;
  logic               take_match;
  logic               take_vict;
  logic               take_free;

  logic [CMP_W-1:0]   cap_ext;
  logic [CMP_W-1:0]   cap_eff;
  logic               cap_zero;
  logic               is_put;
  logic               do_evict;
  logic               need_inval;
  logic [IDX_W-1:0]   ins_idx;
  entry_t             touch_ent;
  entry_t             new_ent;

  logic               ram_we;
  logic [IDX_W-1:0]   ram_waddr;
  entry_t             ram_wdata;

  assign busy      = (state_r != ST_IDLE);
  assign cfg_ready = 1'b1;
  assign accept    = start && !busy;
  assign issue     = (state_r == ST_SCAN) && !issue_done_r;
  assign scan_last = rd_vld_r && (rd_idx_r == LAST_IDX);
  assign rd_ent    = entry_t'(rd_word);

  assign out_valid       = out_valid_r;
  assign out_hit         = out_hit_r;
  assign out_read_value  = out_read_value_r;
  assign out_evicted     = out_evicted_r;
  assign out_evicted_key = out_evicted_key_r;

  // scan compare
  always_comb begin
    take_match = rd_vld_r && rd_ent.vld && (rd_ent.key == key_r) && !match_found_r;
    take_vict  = rd_vld_r && rd_ent.vld &&
                 (!vict_found_r || (rd_ent.count < vict_cnt_r) ||
                  ((rd_ent.count == vict_cnt_r) && (rd_ent.last < vict_last_r)));
    take_free  = rd_vld_r && !rd_ent.vld && !free_found_r;
  end

  // decision
  always_comb begin
    cap_ext    = CMP_W'(cap_r);
    cap_eff    = (cap_ext > CMP_W'(CAPACITY)) ? CMP_W'(CAPACITY) : cap_ext;
    cap_zero   = (cap_eff == '0);
    is_put     = (mode_r == MODE_PUT);
    do_evict   = is_put && !cap_zero && !match_found_r &&
                 (CMP_W'(occ_r) >= cap_eff) && vict_found_r;
    need_inval = do_evict && free_found_r && (free_idx_r < vict_idx_r);
    ins_idx    = (do_evict && !need_inval) ? vict_idx_r : free_idx_r;

    touch_ent       = match_ent_r;
    touch_ent.count = (match_ent_r.count == '1) ? match_ent_r.count
                                                : match_ent_r.count + 1'b1;
    touch_ent.last  = stamp_r;
    if (is_put) begin
      touch_ent.value = val_r;
    end

    new_ent.vld   = 1'b1;
    new_ent.key   = key_r;
    new_ent.value = val_r;
    new_ent.count = COUNT_BITS'(1);
    new_ent.last  = stamp_r;
  end

  // RAM write port
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = clr_idx_r;
    ram_wdata = '0;
    case (state_r)
      ST_CLEAR: begin
        ram_we = 1'b1;
      end
      ST_DECIDE: begin
        if (match_found_r && (!is_put || !cap_zero)) begin
          ram_we    = 1'b1;
          ram_waddr = match_idx_r;
          ram_wdata = touch_ent;
        end else if (is_put && !cap_zero) begin
          ram_we    = 1'b1;
          ram_waddr = ins_idx;
          ram_wdata = new_ent;
        end
      end
      ST_INVAL: begin
        ram_we    = 1'b1;
        ram_waddr = vict_idx_r;
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  lfu_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (issue),
    .raddr (scan_idx_r),
    .rdata (rd_word)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r           <= ST_CLEAR;
      cap_r             <= CAP_RESET;
      occ_r             <= '0;
      access_stamp_r    <= '0;
      clr_idx_r         <= '0;
      scan_idx_r        <= '0;
      issue_done_r      <= 1'b0;
      rd_vld_r          <= 1'b0;
      rd_idx_r          <= '0;
      out_valid_r       <= 1'b0;
      out_hit_r         <= 1'b0;
      out_read_value_r  <= '0;
      out_evicted_r     <= 1'b0;
      out_evicted_key_r <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        cap_r <= cfg_capacity_in_use;
      end
      rd_vld_r    <= issue;
      rd_idx_r    <= scan_idx_r;
      out_valid_r <= 1'b0;
      case (state_r)
        ST_CLEAR: begin
          clr_idx_r <= clr_idx_r + 1'b1;
          if (clr_idx_r == LAST_IDX) begin
            state_r <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (accept) begin
            access_stamp_r <= access_stamp_r + 1'b1;
            scan_idx_r     <= '0;
            issue_done_r   <= 1'b0;
            state_r        <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (issue) begin
            if (scan_idx_r == LAST_IDX) begin
              issue_done_r <= 1'b1;
            end else begin
              scan_idx_r <= scan_idx_r + 1'b1;
            end
          end
          if (scan_last) begin
            state_r <= ST_DECIDE;
          end
        end
        ST_DECIDE: begin
          out_valid_r       <= 1'b1;
          out_hit_r         <= match_found_r && !(is_put && cap_zero);
          out_read_value_r  <= is_put ? '0 : (match_found_r ? match_ent_r.value : MISS_VALUE);
          out_evicted_r     <= do_evict;
          out_evicted_key_r <= do_evict ? vict_key_r : '0;
          if (is_put && !cap_zero && !match_found_r && !do_evict) begin
            occ_r <= occ_r + 1'b1;
          end
          state_r <= need_inval ? ST_INVAL : ST_IDLE;
        end
        ST_INVAL: begin
          state_r <= ST_IDLE;
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  // request and scan trackers
  always_ff @(posedge clk) begin
    if (accept) begin
      mode_r        <= in_mode;
      key_r         <= in_lookup_key;
      val_r         <= in_store_value;
      stamp_r       <= access_stamp_r;
      match_found_r <= 1'b0;
      vict_found_r  <= 1'b0;
      free_found_r  <= 1'b0;
    end else begin
      if (take_match) begin
        match_found_r <= 1'b1;
        match_idx_r   <= rd_idx_r;
        match_ent_r   <= rd_ent;
      end
      if (take_vict) begin
        vict_found_r <= 1'b1;
        vict_idx_r   <= rd_idx_r;
        vict_key_r   <= rd_ent.key;
        vict_cnt_r   <= rd_ent.count;
        vict_last_r  <= rd_ent.last;
      end
      if (take_free) begin
        free_found_r <= 1'b1;
        free_idx_r   <= rd_idx_r;
      end
    end
  end

`ifndef ASSERT_OFF
  a_strobe_after_work: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy))
    else $error("result strobe without a request in progress");

  a_accept_goes_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted item did not raise busy");

  a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
    occ_r <= CNT_W'(CAPACITY))
    else $error("occupancy above capacity");

  a_evict_only_on_miss: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_evicted |-> !out_hit)
    else $error("eviction reported on a hit");
`endif

endmodule

FILE: sv/lfu_ram.sv
// ----------------------------------------------------------------------------
// LFU table entry RAM
// Single write port, single registered read port.
// ----------------------------------------------------------------------------
module lfu_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                       clk,
  input  logic                                       we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                           wdata,
  input  logic                                       re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                           rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
